// ===== hdl/r2yuv_pkg.sv =====
// shared types, constants and helpers for the rgb to yuv 4:2:0 converter
package r2yuv_pkg;

   // frame geometry limits
   localparam int MAX_LINE_PAIRS = 2048;
   localparam int MAX_ROWS       = 4096;

   // counter widths follow from the limits
   localparam int COL_W      = $clog2(MAX_LINE_PAIRS);
   localparam int ROW_W      = $clog2(MAX_ROWS);
   localparam int PAIR_CNT_W = $clog2(MAX_LINE_PAIRS + 1);
   localparam int ROW_CNT_W  = $clog2(MAX_ROWS + 1);

   // register widths and field widths
   localparam int LINE_PAIRS_W = 12;
   localparam int FRAME_ROWS_W = 13;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 2;
   localparam int PIX_W        = 8;
   localparam int REQ_DATA_W   = 6 * PIX_W;
   localparam int RSP_DATA_W   = 4 * PIX_W;
   localparam int RSP_USER_W   = 2;

   // reset values of the registers
   localparam logic [LINE_PAIRS_W-1:0] LINE_PAIRS_RST = LINE_PAIRS_W'(320);
   localparam logic [FRAME_ROWS_W-1:0] FRAME_ROWS_RST = FRAME_ROWS_W'(480);

   // luma coefficients
   localparam int Y_R   = 66;
   localparam int Y_G   = 129;
   localparam int Y_B   = 25;
   localparam int Y_OFS = 16;

   // chroma coefficients (bt.601 values halved, shift of seven)
   localparam int CB_B = 112 / 2;
   localparam int CB_G = -74 / 2;
   localparam int CB_R = -38 / 2;
   localparam int CR_R = 112 / 2;
   localparam int CR_G = -94 / 2;
   localparam int CR_B = -18 / 2;
   localparam int C_OFS = 128;
   localparam int C_MAX = 'hFF;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LINE_PAIRS    = 2'd0,
      CSR_FRAME_ROWS    = 2'd1,
      CSR_CHANNEL_ORDER = 2'd2
   } csr_index_type;

   // one pixel after channel ordering
   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
   } rgb_type;

   // position flags carried along with a request
   typedef struct packed {
      logic chroma_valid;
      logic line_end;
      logic frame_end;
   } pos_flags_type;

   // force a count into 1..maxv
   function automatic int clamp_count(input int v, input int maxv);
      int r;
      r = v;
      if (v < 1) r = 1;
      else if (v > maxv) r = maxv;
      return r;
   endfunction

endpackage

// ===== hdl/r2yuv_luma_lane.sv =====
// luma lane: one pixel to its bt.601 luma sample
module r2yuv_luma_lane
   import r2yuv_pkg::*;
(
   input  rgb_type          pixel,
   output logic [PIX_W-1:0] luma
);

   logic [15:0] sum;

   // weighted sum, truncated by eight bits, then offset
   always_comb begin
      sum  = 16'(Y_R) * 16'(pixel.red) + 16'(Y_G) * 16'(pixel.green)
           + 16'(Y_B) * 16'(pixel.blue);
      luma = sum[15:8] + PIX_W'(Y_OFS);
   end

endmodule

// ===== hdl/r2yuv_chroma_unit.sv =====
// chroma unit: cb and cr of the first pixel, zero on odd rows
module r2yuv_chroma_unit
   import r2yuv_pkg::*;
(
   input  rgb_type          pixel,
   input  logic             even_row,
   output logic [PIX_W-1:0] cb,
   output logic [PIX_W-1:0] cr
);

   // floor shift by seven, offset, clamp to a byte
   function automatic logic [PIX_W-1:0] finish(input logic signed [16:0] s);
      logic signed [9:0] q;
      logic signed [10:0] t;
      logic [PIX_W-1:0] r;
      q = 10'(s >>> 7);
      t = 11'(q) + 11'(C_OFS);
      if (t < 0) r = '0;
      else if (t > 11'(C_MAX)) r = PIX_W'(C_MAX);
      else r = t[PIX_W-1:0];
      return r;
   endfunction

   logic signed [16:0] r_s, g_s, b_s;
   logic signed [16:0] cb_sum, cr_sum;

   // weighted differences in signed arithmetic
   always_comb begin
      r_s    = $signed({9'd0, pixel.red});
      g_s    = $signed({9'd0, pixel.green});
      b_s    = $signed({9'd0, pixel.blue});
      cb_sum = 17'(CB_B) * b_s + 17'(CB_G) * g_s + 17'(CB_R) * r_s;
      cr_sum = 17'(CR_R) * r_s + 17'(CR_G) * g_s + 17'(CR_B) * b_s;
      cb     = even_row ? finish(cb_sum) : '0;
      cr     = even_row ? finish(cr_sum) : '0;
   end

endmodule

// ===== hdl/rgb_to_yuv420_converter_unit.sv =====
// Converts a stream of rgb pixel pairs to luma for both pixels and 4:2:0 chroma
// (first pixel of the pair, even rows only). One request is taken every clock
// cycle while the result side keeps up; with rsp_tready low and both stages full,
// req_tready drops until the result is taken. A request passes through the input
// capture register and then the result register before its result is on the
// output. Two luma lanes and one chroma unit work side by side on a pair, and the
// result register merges them with the line and frame position flags. Registers
// are to be written only while the block is idle; the user must keep to this, as
// the block does not enforce it. Outputs: rsp_tlast marks the last pair of a line.
module rgb_to_yuv420_converter_unit
   import r2yuv_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // configuration writes
   input  logic                  csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   // pixel pair requests
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // first_ch0, first_ch1, first_ch2, second_ch0, second_ch1, second_ch2
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // results
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // first_luma, second_luma, cb_value, cr_value
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // chroma_valid, frame_end
   output logic [RSP_USER_W-1:0] rsp_tuser,
   output logic                  rsp_tlast
);

   logic [LINE_PAIRS_W-1:0] line_pairs_ff;
   logic [FRAME_ROWS_W-1:0] frame_rows_ff;
   logic                    order_ff;
   logic [COL_W-1:0]        col_ff, col_in;
   logic [ROW_W-1:0]        row_ff, row_in;
   logic                    s1_valid_ff, s1_valid_in;
   logic [REQ_DATA_W-1:0]   s1_data_ff;
   pos_flags_type           s1_flags_ff, flags_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   pos_flags_type           rsp_flags_ff;
   logic                    req_acc, s2_load;
   logic [PAIR_CNT_W-1:0]   pairs_lim, col_next;
   logic [ROW_CNT_W-1:0]    rows_lim, row_next;
   rgb_type                 pix_a, pix_b;
   logic [PIX_W-1:0]        luma_a, luma_b, cb, cr;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         line_pairs_ff <= LINE_PAIRS_RST;
         frame_rows_ff <= FRAME_ROWS_RST;
         order_ff      <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LINE_PAIRS:    line_pairs_ff <= csr_wdata[LINE_PAIRS_W-1:0];
            CSR_FRAME_ROWS:    frame_rows_ff <= csr_wdata[FRAME_ROWS_W-1:0];
            CSR_CHANNEL_ORDER: order_ff      <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // pipeline handshake: each stage loads when empty or draining
   always_comb begin
      s2_load      = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
      req_tready   = !s1_valid_ff || s2_load;
      req_acc      = req_tvalid && req_tready;
      s1_valid_in  = req_acc || (s1_valid_ff && !s2_load);
      rsp_valid_in = s2_load || (rsp_valid_ff && !rsp_tready);
   end

   // position of the request in the frame
   always_comb begin
      pairs_lim = PAIR_CNT_W'(clamp_count(int'(line_pairs_ff), MAX_LINE_PAIRS));
      rows_lim  = ROW_CNT_W'(clamp_count(int'(frame_rows_ff), MAX_ROWS));
      col_next  = PAIR_CNT_W'(col_ff) + PAIR_CNT_W'(1);
      row_next  = ROW_CNT_W'(row_ff) + ROW_CNT_W'(1);
      flags_in.chroma_valid = !row_ff[0];
      flags_in.line_end     = col_next >= pairs_lim;
      flags_in.frame_end    = flags_in.line_end && (row_next >= rows_lim);
      col_in = col_ff;
      row_in = row_ff;
      if (req_acc) begin
         if (flags_in.line_end) begin
            col_in = '0;
            row_in = flags_in.frame_end ? '0 : row_next[ROW_W-1:0];
         end else begin
            col_in = col_next[COL_W-1:0];
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input capture register
   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_data_ff  <= req_tdata;
         s1_flags_ff <= flags_in;
      end
   end

   // channel ordering for both pixels
   always_comb begin
      pix_a.green = s1_data_ff[15:8];
      pix_b.green = s1_data_ff[39:32];
      if (order_ff) begin
         pix_a.red  = s1_data_ff[23:16];
         pix_a.blue = s1_data_ff[7:0];
         pix_b.red  = s1_data_ff[47:40];
         pix_b.blue = s1_data_ff[31:24];
      end else begin
         pix_a.red  = s1_data_ff[7:0];
         pix_a.blue = s1_data_ff[23:16];
         pix_b.red  = s1_data_ff[31:24];
         pix_b.blue = s1_data_ff[47:40];
      end
   end

   // lanes
   r2yuv_luma_lane u_luma_a (.pixel(pix_a), .luma(luma_a));
   r2yuv_luma_lane u_luma_b (.pixel(pix_b), .luma(luma_b));
   r2yuv_chroma_unit u_chroma (
      .pixel    (pix_a),
      .even_row (s1_flags_ff.chroma_valid),
      .cb       (cb),
      .cr       (cr)
   );

   // merge lane outputs into the result register
   assign rsp_data_in = {cr, cb, luma_b, luma_a};

   always_ff @(posedge clock) begin
      if (s2_load) begin
         rsp_data_ff  <= rsp_data_in;
         rsp_flags_ff <= s1_flags_ff;
      end
   end

   // result port
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = {rsp_flags_ff.frame_end, rsp_flags_ff.chroma_valid};
   assign rsp_tlast  = rsp_flags_ff.line_end;

   // a frame always ends on a line end
   a_frame_on_line: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast)
      else $error("frame end without line end");

   // odd rows carry zero chroma
   a_odd_chroma_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[31:16] == '0)
      else $error("chroma on odd row not zero");

   // column returns to zero after a line end request
   a_col_wrap: assert property (@(posedge clock) disable iff (reset)
      req_acc && flags_in.line_end |=> col_ff == '0)
      else $error("column counter did not wrap");

   // nothing valid straight after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid && !s1_valid_ff)
      else $error("pipeline not empty after reset");

endmodule

// ===== tb/sv/tb_top.sv =====
// testbench for the rgb to yuv 4:2:0 converter: directed and random pairs against a predictor
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import r2yuv_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int SETTLE_CYCLES  = 4;
   localparam int MAX_REPORTS    = 100;
   localparam int OVERSIZE_ITEMS = 64;
   // register index that the block does not decode
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 2'd3;

   // one pixel as it travels on the request bus
   typedef struct packed {
      logic [PIX_W-1:0] ch0;
      logic [PIX_W-1:0] ch1;
      logic [PIX_W-1:0] ch2;
   } pixel_type;

   typedef struct {
      pixel_type first_px;
      pixel_type second_px;
   } pixel_pair_type;

   typedef struct {
      logic [PIX_W-1:0] first_luma;
      logic [PIX_W-1:0] second_luma;
      logic             chroma_valid;
      logic [PIX_W-1:0] cb_value;
      logic [PIX_W-1:0] cr_value;
      logic             line_end;
      logic             frame_end;
   } yuv_result_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // first_ch0, first_ch1, first_ch2, second_ch0, second_ch1, second_ch2
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // first_luma, second_luma, cb_value, cr_value
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   // chroma_valid, frame_end
   logic [RSP_USER_W-1:0]  rsp_tuser;
   logic                   rsp_tlast;

   // predictor copy of the registers and the position counters
   logic [LINE_PAIRS_W-1:0] model_line_pairs = LINE_PAIRS_RST;
   logic [FRAME_ROWS_W-1:0] model_frame_rows = FRAME_ROWS_RST;
   logic                    model_order      = 1'b0;
   logic [COL_W-1:0]        model_col        = '0;
   logic [ROW_W-1:0]        model_row        = '0;

   yuv_result_type pending_yuv[$];
   int             mismatch_count = 0;
   int             results_seen   = 0;
   int             stall_cycles   = 0;
   int             send_idle_pct  = 0;
   int             recv_idle_pct  = 0;

   rgb_to_yuv420_converter_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   // zero counts as one, anything past the limit is held at the limit
   function automatic int effective_count(input int v, input int maxv);
      if (v < 1) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   function automatic rgb_type order_pixel(input pixel_type p);
      rgb_type c;
      c.green = p.ch1;
      if (model_order) begin
         c.red  = p.ch2;
         c.blue = p.ch0;
      end else begin
         c.red  = p.ch0;
         c.blue = p.ch2;
      end
      return c;
   endfunction

   function automatic logic [PIX_W-1:0] luma_of_pixel(input rgb_type c);
      int s;
      s = Y_R * int'(c.red) + Y_G * int'(c.green) + Y_B * int'(c.blue);
      return PIX_W'((s >> 8) + Y_OFS);
   endfunction

   // floor shift by seven, offset, then clip to a byte
   function automatic logic [PIX_W-1:0] chroma_of_sum(input int s);
      int q;
      q = (s >>> 7) + C_OFS;
      if (q < 0) q = 0;
      else if (q > C_MAX) q = C_MAX;
      return PIX_W'(q);
   endfunction

   // expected result of one request; advances the counters
   function automatic yuv_result_type predict_yuv(input pixel_pair_type p);
      yuv_result_type r;
      rgb_type        a;
      rgb_type        b;
      int             pairs;
      int             rows;
      pairs = effective_count(int'(model_line_pairs), MAX_LINE_PAIRS);
      rows  = effective_count(int'(model_frame_rows), MAX_ROWS);
      a = order_pixel(p.first_px);
      b = order_pixel(p.second_px);
      r.first_luma   = luma_of_pixel(a);
      r.second_luma  = luma_of_pixel(b);
      r.chroma_valid = ~model_row[0];
      r.cb_value     = '0;
      r.cr_value     = '0;
      if (r.chroma_valid) begin
         r.cb_value = chroma_of_sum(CB_B * int'(a.blue) + CB_G * int'(a.green)
                                    + CB_R * int'(a.red));
         r.cr_value = chroma_of_sum(CR_R * int'(a.red) + CR_G * int'(a.green)
                                    + CR_B * int'(a.blue));
      end
      r.line_end  = (int'(model_col) + 1 >= pairs);
      r.frame_end = r.line_end && (int'(model_row) + 1 >= rows);
      if (r.line_end) begin
         model_col = '0;
         model_row = r.frame_end ? '0 : model_row + 1'b1;
      end else begin
         model_col = model_col + 1'b1;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   function automatic pixel_pair_type make_pair(input logic [7:0] a0, a1, a2, b0, b1, b2);
      pixel_pair_type p;
      p.first_px  = '{ch0: a0, ch1: a1, ch2: a2};
      p.second_px = '{ch0: b0, ch1: b1, ch2: b2};
      return p;
   endfunction

   // biased toward the ends of the range
   function automatic logic [PIX_W-1:0] random_channel();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return PIX_W'($urandom);
      endcase
   endfunction

   function automatic pixel_pair_type random_pair();
      return make_pair(random_channel(), random_channel(), random_channel(),
                       random_channel(), random_channel(), random_channel());
   endfunction

   // one request, with random idle cycles in front of it
   task automatic send_pair(input pixel_pair_type p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {p.second_px.ch2, p.second_px.ch1, p.second_px.ch0,
                     p.first_px.ch2, p.first_px.ch1, p.first_px.ch0};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_yuv.push_back(predict_yuv(p));
   endtask

   // stop sending and let every result drain out
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (pending_yuv.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_LINE_PAIRS:    model_line_pairs = value[LINE_PAIRS_W-1:0];
         CSR_FRAME_ROWS:    model_frame_rows = value[FRAME_ROWS_W-1:0];
         CSR_CHANNEL_ORDER: model_order      = value[0];
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------- tests

   // black, white, primaries and small negative chroma sums, in both channel orders
   task automatic test_color_extremes();
      pixel_pair_type colors[5];
      colors[0] = make_pair(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF);
      colors[1] = make_pair(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00);
      colors[2] = make_pair(8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00);
      colors[3] = make_pair(8'h00, 8'h00, 8'hFF, 8'h01, 8'h00, 8'h00);
      colors[4] = make_pair(8'h01, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF);
      foreach (colors[i]) send_pair(colors[i]);
      settle_block();
      // upper data bits set, only bit zero counts
      write_reg(CSR_CHANNEL_ORDER, 13'h1FFF);
      write_reg(CSR_UNUSED_INDEX, CSR_DATA_W'($urandom));
      foreach (colors[i]) send_pair(colors[i]);
      settle_block();
      write_reg(CSR_CHANNEL_ORDER, 13'h1FFE);
   endtask

   // odd row count: the last row is even and carries chroma
   task automatic test_odd_frame();
      write_reg(CSR_LINE_PAIRS, 13'h1001);
      write_reg(CSR_FRAME_ROWS, 13'd3);
      repeat (7) send_pair(random_pair());
      settle_block();
   endtask

   // zero sizes behave as one: every request ends a line and a frame
   task automatic test_zero_sizes();
      write_reg(CSR_LINE_PAIRS, 13'd0);
      write_reg(CSR_FRAME_ROWS, 13'd0);
      repeat (3) send_pair(random_pair());
      settle_block();
   endtask

   // shrink the line while the column counter is past the new end
   task automatic test_resize_between_runs();
      write_reg(CSR_LINE_PAIRS, 13'd4);
      write_reg(CSR_FRAME_ROWS, 13'd4);
      repeat (6) send_pair(random_pair());
      settle_block();
      write_reg(CSR_LINE_PAIRS, 13'd2);
      repeat (3) send_pair(random_pair());
      settle_block();
   endtask

   // random frames of small geometry, new settings every chunk
   task automatic test_random_traffic(input int n_items);
      int                    sent;
      int                    chunk;
      logic [CSR_DATA_W-1:0] lp;
      logic [CSR_DATA_W-1:0] fr;
      sent = 0;
      while (sent < n_items) begin
         settle_block();
         case ($urandom_range(9))
            0: lp = CSR_DATA_W'($urandom_range(9, 40));
            1: lp = '0;
            default: lp = CSR_DATA_W'($urandom_range(1, 8));
         endcase
         case ($urandom_range(9))
            0: fr = CSR_DATA_W'($urandom_range(0, 1));
            1: fr = CSR_DATA_W'($urandom_range(9, 20));
            default: fr = CSR_DATA_W'($urandom_range(2, 8));
         endcase
         write_reg(CSR_LINE_PAIRS, lp);
         write_reg(CSR_FRAME_ROWS, fr);
         write_reg(CSR_CHANNEL_ORDER, CSR_DATA_W'($urandom_range(1)));
         chunk = $urandom_range(60, 120);
         repeat (chunk) send_pair(random_pair());
         sent += chunk;
      end
      settle_block();
   endtask

   // largest register values saturate: a long run with no line or frame end
   task automatic test_oversized_sizes();
      // realign both counters to the start of a frame
      write_reg(CSR_LINE_PAIRS, 13'd1);
      write_reg(CSR_FRAME_ROWS, 13'd1);
      send_pair(random_pair());
      settle_block();
      write_reg(CSR_LINE_PAIRS, 13'h0FFF);
      write_reg(CSR_FRAME_ROWS, 13'h1FFF);
      repeat (OVERSIZE_ITEMS) send_pair(random_pair());
      settle_block();
      // column far past a one pair line: ends line and frame at once
      write_reg(CSR_LINE_PAIRS, 13'd1);
      write_reg(CSR_FRAME_ROWS, 13'd1);
      send_pair(random_pair());
      settle_block();
   endtask

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what, input logic [PIX_W-1:0] got,
                                  input logic [PIX_W-1:0] want);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("mismatch at result %0d: %s got %0h expected %0h",
                  results_seen, what, got, want);
   endtask

   task automatic check_result();
      yuv_result_type want;
      if (pending_yuv.size() == 0) begin
         report_mismatch("result with no request pending", '0, '0);
      end else begin
         want = pending_yuv.pop_front();
         if (rsp_tdata[7:0] !== want.first_luma)
            report_mismatch("first_luma", rsp_tdata[7:0], want.first_luma);
         if (rsp_tdata[15:8] !== want.second_luma)
            report_mismatch("second_luma", rsp_tdata[15:8], want.second_luma);
         if (rsp_tdata[23:16] !== want.cb_value)
            report_mismatch("cb_value", rsp_tdata[23:16], want.cb_value);
         if (rsp_tdata[31:24] !== want.cr_value)
            report_mismatch("cr_value", rsp_tdata[31:24], want.cr_value);
         if (rsp_tuser[0] !== want.chroma_valid)
            report_mismatch("chroma_valid", PIX_W'(rsp_tuser[0]),
                            PIX_W'(want.chroma_valid));
         if (rsp_tuser[1] !== want.frame_end)
            report_mismatch("frame_end", PIX_W'(rsp_tuser[1]), PIX_W'(want.frame_end));
         if (rsp_tlast !== want.line_end)
            report_mismatch("line_end", PIX_W'(rsp_tlast), PIX_W'(want.line_end));
      end
      results_seen++;
   endtask

   // result side: check accepted results, stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_result();
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("rgb_to_yuv420_converter_unit regression: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 20;
      recv_idle_pct = 67;
      test_color_extremes();
      test_odd_frame();
      test_zero_sizes();
      test_resize_between_runs();
      test_random_traffic(360);

      send_idle_pct = 67;
      recv_idle_pct = 20;
      test_random_traffic(360);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(370);
      test_oversized_sizes();

      settle_block();
      if (mismatch_count == 0)
         $display("rgb_to_yuv420_converter_unit regression: pass");
      else
         $display("rgb_to_yuv420_converter_unit regression: fail");
      $finish;
   end

endmodule
